@@ design/rltc_pkg.sv @@
// ----------------------------------------------------------------------------
// rltc_pkg
// shared types and constants for the run-length text compressor
// ----------------------------------------------------------------------------
package rltc_pkg;

   localparam int RUN_W = 20;
   localparam logic [RUN_W-1:0] MAX_RUN = 20'd1048575;

   // reciprocal of ten: q = (x * RECIP_TEN) >> RECIP_SHIFT, exact for x < 2**22
   localparam logic [RUN_W-1:0] RECIP_TEN = 20'd838861;
   localparam int RECIP_SHIFT = 23;
   localparam int PROD_W = 2 * RUN_W;
   localparam int QUOT_W = PROD_W - RECIP_SHIFT;

   // a 20-bit count has at most 7 decimal digits
   localparam int DIG_DEPTH = 8;
   localparam int DIG_IDX_W = 3;

   localparam logic [7:0] ASCII_ZERO = 8'h30;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_stream;
   } req_word_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        item_last;
      logic        stream_done;
      logic [31:0] total_length;
   } rsp_word_type;

   typedef struct packed {
      logic capture;
      logic inc_run;
      logic new_run;
      logic end_stream;
      logic emit_byte;
      logic conv_load;
      logic conv_mul;
      logic conv_push;
      logic emit_digit;
      logic out_last;
      logic out_done;
   } dp_cmd_type;

   typedef struct packed {
      logic extend;
      logic run_open;
      logic eos;
      logic len_gt1;
      logic quot_zero;
      logic out_free;
      logic dig_one;
   } dp_status_type;

endpackage

@@ design/rltc_dpath.sv @@
// ----------------------------------------------------------------------------
// rltc_dpath
// run state, decimal digit conversion, digit stack and output register
// ----------------------------------------------------------------------------
module rltc_dpath (
   input  logic                   clock,
   input  logic                   reset,
   input  rltc_pkg::req_word_type req_word,
   input  rltc_pkg::dp_cmd_type   cmd,
   output rltc_pkg::dp_status_type status,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rltc_pkg::rsp_word_type rsp_word
);

   rltc_pkg::req_word_type in_ff;
   logic [7:0]                    run_byte_ff, run_byte_in;
   logic [rltc_pkg::RUN_W-1:0]    run_len_ff, run_len_in;
   logic                          run_open_ff, run_open_in;
   logic [31:0]                   written_ff, written_in;
   logic [rltc_pkg::RUN_W-1:0]    conv_ff;
   logic [rltc_pkg::PROD_W-1:0]   prod_ff;
   logic [3:0]                    dig_ff [rltc_pkg::DIG_DEPTH];
   logic [rltc_pkg::DIG_IDX_W-1:0] ndig_ff, ndig_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   rltc_pkg::rsp_word_type        rsp_ff, rsp_in;

   logic [rltc_pkg::QUOT_W-1:0]   quot;
   logic [rltc_pkg::RUN_W-1:0]    quot_ext, times_ten, remainder;
   logic [rltc_pkg::DIG_IDX_W-1:0] top_idx;
   logic [31:0]                   total;
   logic                          out_free;

   // one digit per multiply / subtract pair
   assign quot      = prod_ff[rltc_pkg::PROD_W-1:rltc_pkg::RECIP_SHIFT];
   assign quot_ext  = rltc_pkg::RUN_W'(quot);
   assign times_ten = (quot_ext << 3) + (quot_ext << 1);
   assign remainder = conv_ff - times_ten;
   assign top_idx   = ndig_ff - 3'd1;
   assign total     = written_ff + 32'd1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign status.extend    = run_open_ff && (in_ff.in_byte == run_byte_ff)
                             && (run_len_ff < rltc_pkg::MAX_RUN);
   assign status.run_open  = run_open_ff;
   assign status.eos       = in_ff.end_of_stream;
   assign status.len_gt1   = run_len_ff > 20'd1;
   assign status.quot_zero = quot == '0;
   assign status.out_free  = out_free;
   assign status.dig_one   = ndig_ff == 3'd1;

   always_comb begin
      run_byte_in  = run_byte_ff;
      run_len_in   = run_len_ff;
      run_open_in  = run_open_ff;
      written_in   = written_ff;
      ndig_in      = ndig_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (cmd.inc_run) begin
         run_len_in = run_len_ff + 20'd1;
      end
      if (cmd.new_run) begin
         run_byte_in = in_ff.in_byte;
         run_len_in  = 20'd1;
         run_open_in = 1'b1;
      end
      if (cmd.end_stream) begin
         run_len_in  = '0;
         run_open_in = 1'b0;
         written_in  = '0;
      end
      if (cmd.conv_load) begin
         ndig_in = '0;
      end
      if (cmd.conv_push) begin
         ndig_in = ndig_ff + 3'd1;
      end
      if (cmd.emit_byte || cmd.emit_digit) begin
         rsp_valid_in             = 1'b1;
         rsp_in.out_byte          = cmd.emit_byte ? run_byte_ff
                                    : rltc_pkg::ASCII_ZERO + {4'b0, dig_ff[top_idx]};
         rsp_in.item_last         = cmd.out_last;
         rsp_in.stream_done       = cmd.out_done;
         rsp_in.total_length      = total;
         written_in               = total;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit_digit) begin
         ndig_in = top_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_byte_ff  <= '0;
         run_len_ff   <= '0;
         run_open_ff  <= 1'b0;
         written_ff   <= '0;
         ndig_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         run_byte_ff  <= run_byte_in;
         run_len_ff   <= run_len_in;
         run_open_ff  <= run_open_in;
         written_ff   <= written_in;
         ndig_ff      <= ndig_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (cmd.capture) begin
         in_ff <= req_word;
      end
      if (cmd.conv_load) begin
         conv_ff <= run_len_ff;
      end
      if (cmd.conv_mul) begin
         prod_ff <= {20'b0, conv_ff} * {20'b0, rltc_pkg::RECIP_TEN};
      end
      if (cmd.conv_push) begin
         dig_ff[ndig_ff] <= remainder[3:0];
         conv_ff         <= quot_ext;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // a word is never loaded over one still waiting to be taken
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_byte || cmd.emit_digit) |-> out_free)
      else $error("word loaded into a full output register");

   // digit stack never overflows
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      cmd.conv_push |-> ndig_ff != 3'd7)
      else $error("digit stack overflow");

   // digits are only popped from a non-empty stack
   a_pop_full: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_digit |-> ndig_ff != '0)
      else $error("digit pop from empty stack");

   // stream end leaves no run open and a fresh byte count
   a_stream_end: assert property (@(posedge clock) disable iff (reset)
      cmd.end_stream |=> (!run_open_ff && written_ff == '0))
      else $error("stream end did not clear run state");

endmodule

@@ design/rltc_ctrl.sv @@
// ----------------------------------------------------------------------------
// rltc_ctrl
// sequencer for run decisions, run flushes and digit conversion
// ----------------------------------------------------------------------------
module rltc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  rltc_pkg::dp_status_type status,
   output rltc_pkg::dp_cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_EMIT_BYTE,
      S_CONV_MUL,
      S_CONV_DIV,
      S_EMIT_DIGIT,
      S_FLUSH_END
   } state_type;

   state_type state_ff, state_in;
   logic      final_ff, final_in;         // this flush ends the item
   logic      eos_flush_ff, eos_flush_in; // this flush ends the stream

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      final_in     = final_ff;
      eos_flush_in = eos_flush_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (status.extend) begin
               cmd.inc_run = 1'b1;
               if (status.eos) begin
                  eos_flush_in = 1'b1;
                  final_in     = 1'b1;
                  state_in     = S_EMIT_BYTE;
               end else begin
                  state_in = S_IDLE;
               end
            end else if (status.run_open) begin
               eos_flush_in = 1'b0;
               final_in     = !status.eos;
               state_in     = S_EMIT_BYTE;
            end else begin
               cmd.new_run = 1'b1;
               if (status.eos) begin
                  eos_flush_in = 1'b1;
                  final_in     = 1'b1;
                  state_in     = S_EMIT_BYTE;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_EMIT_BYTE: begin
            if (status.out_free) begin
               cmd.emit_byte = 1'b1;
               cmd.out_last  = final_ff && !status.len_gt1;
               cmd.out_done  = eos_flush_ff && !status.len_gt1;
               if (status.len_gt1) begin
                  cmd.conv_load = 1'b1;
                  state_in      = S_CONV_MUL;
               end else begin
                  state_in = S_FLUSH_END;
               end
            end
         end
         S_CONV_MUL: begin
            cmd.conv_mul = 1'b1;
            state_in     = S_CONV_DIV;
         end
         S_CONV_DIV: begin
            cmd.conv_push = 1'b1;
            state_in      = status.quot_zero ? S_EMIT_DIGIT : S_CONV_MUL;
         end
         S_EMIT_DIGIT: begin
            if (status.out_free) begin
               cmd.emit_digit = 1'b1;
               cmd.out_last   = final_ff && status.dig_one;
               cmd.out_done   = eos_flush_ff && status.dig_one;
               if (status.dig_one) begin
                  state_in = S_FLUSH_END;
               end
            end
         end
         S_FLUSH_END: begin
            if (eos_flush_ff) begin
               cmd.end_stream = 1'b1;
               state_in       = S_IDLE;
            end else begin
               cmd.new_run = 1'b1;
               if (status.eos) begin
                  eos_flush_in = 1'b1;
                  final_in     = 1'b1;
                  state_in     = S_EMIT_BYTE;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         final_ff     <= 1'b0;
         eos_flush_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         final_ff     <= final_in;
         eos_flush_ff <= eos_flush_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;

endmodule

@@ design/run_length_text_compressor.sv @@
// ----------------------------------------------------------------------------
// run_length_text_compressor
// byte-stream run-length compressor with ASCII decimal run counts
// ----------------------------------------------------------------------------
// Takes one byte per word and writes each run as its byte, followed by the
// run length in ASCII decimal (most significant digit first) when the run is
// longer than one. A run is closed by a different byte, by the end-of-stream
// mark, or when one more equal byte arrives at 1048575 bytes. Every output
// word carries the running count of bytes written; the count and the run state
// clear after the word flagged stream_done. Items are handled one at a time: a
// byte that extends or opens a run is accepted and then decided. Closing a run
// writes the run byte and, for a run longer than one, its decimal digits (a
// shared multiply-by-reciprocal divide by ten yields one digit per multiply and
// push step, then each digit is popped from a small stack and written out). An
// item that closes a run and then ends the stream flushes its own new run too.
// The output register lets the next item be accepted while the last word still
// waits; a stalled output holds the sequencer in its emit states.
// ----------------------------------------------------------------------------
module run_length_text_compressor (
   input  logic                   clock,
   input  logic                   reset,
   // input byte channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  rltc_pkg::req_word_type req_word,
   // compressed output channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rltc_pkg::rsp_word_type rsp_word
);

   // command and status between sequencer and datapath
   rltc_pkg::dp_cmd_type    cmd;
   rltc_pkg::dp_status_type status;

   // sequencer: run decisions, flush order, word flags
   rltc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: run registers, divide by ten, digit stack, output register
   rltc_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule

@@ tb/rltc_checker.sv @@
// ----------------------------------------------------------------------------
// rltc_checker
// watches both channels of the compressor, predicts and compares output words
// ----------------------------------------------------------------------------
module rltc_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  rltc_pkg::req_word_type req_word,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  rltc_pkg::rsp_word_type rsp_word,
   output int                     fail_count,
   output int                     pending
);
   timeunit 1ns;
   timeprecision 1ps;

   rltc_pkg::rsp_word_type         pending_words [$];
   logic [7:0]                     cur_byte;
   logic [rltc_pkg::RUN_W-1:0]     cur_len;
   logic                           run_on;
   logic [31:0]                    written;

   task automatic log_failure(input string msg);
      if (fail_count < 10) $display("%0t ns mismatch: %s", $time, msg);
      fail_count++;
   endtask

   task automatic emit_word(input logic [7:0] b);
      rltc_pkg::rsp_word_type w;
      written = written + 32'd1;
      w.out_byte     = b;
      w.item_last    = 1'b0;
      w.stream_done  = 1'b0;
      w.total_length = written;
      pending_words.push_back(w);
   endtask

   // run byte, then the count in decimal when the run is longer than one
   task automatic close_run();
      logic [7:0]                 digits [rltc_pkg::DIG_DEPTH];
      logic [rltc_pkg::RUN_W-1:0] len;
      int                         n;
      emit_word(cur_byte);
      if (cur_len > rltc_pkg::RUN_W'(1)) begin
         len = cur_len;
         n = 0;
         while (len != 0) begin
            digits[n] = rltc_pkg::ASCII_ZERO + 8'(len % rltc_pkg::RUN_W'(10));
            n++;
            len = len / rltc_pkg::RUN_W'(10);
         end
         while (n > 0) begin
            n--;
            emit_word(digits[n]);
         end
      end
   endtask

   task automatic compress_byte(input rltc_pkg::req_word_type w);
      rltc_pkg::rsp_word_type tail;
      int                     first;
      first = pending_words.size();
      if (run_on && w.in_byte == cur_byte && cur_len < rltc_pkg::MAX_RUN) begin
         cur_len = cur_len + rltc_pkg::RUN_W'(1);
      end else begin
         if (run_on) close_run();
         cur_byte = w.in_byte;
         cur_len  = rltc_pkg::RUN_W'(1);
         run_on   = 1'b1;
      end
      if (w.end_of_stream) begin
         close_run();
         tail = pending_words.pop_back();
         tail.stream_done = 1'b1;
         pending_words.push_back(tail);
         run_on  = 1'b0;
         cur_len = '0;
         written = '0;
      end
      if (pending_words.size() > first) begin
         tail = pending_words.pop_back();
         tail.item_last = 1'b1;
         pending_words.push_back(tail);
      end
   endtask

   always @(posedge clock) begin : watch
      rltc_pkg::rsp_word_type want;
      if (reset) begin
         pending_words.delete();
         cur_byte   = '0;
         cur_len    = '0;
         run_on     = 1'b0;
         written    = '0;
         fail_count = 0;
      end else begin
         if (req_valid && !req_stall) compress_byte(req_word);
         if (rsp_valid && !rsp_stall) begin
            if (pending_words.size() == 0) begin
               log_failure($sformatf("unexpected word byte %02h total %0d",
                                     rsp_word.out_byte, rsp_word.total_length));
            end else begin
               want = pending_words.pop_front();
               if (rsp_word.out_byte !== want.out_byte ||
                   rsp_word.item_last !== want.item_last ||
                   rsp_word.stream_done !== want.stream_done ||
                   rsp_word.total_length !== want.total_length)
                  log_failure($sformatf(
                     "expected byte %02h last %0b done %0b total %0d, got %02h %0b %0b %0d",
                     want.out_byte, want.item_last, want.stream_done, want.total_length,
                     rsp_word.out_byte, rsp_word.item_last, rsp_word.stream_done,
                     rsp_word.total_length));
            end
         end
      end
      pending = pending_words.size();
   end

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the run-length text compressor
// ----------------------------------------------------------------------------
// Feeds byte streams through the compressor: a directed set covering the byte
// extremes, single bytes, runs with one and two digit counts and end marks on
// both new and extended runs, then random streams under several idle and
// stall mixes. A checker beside the block predicts every output word and
// counts mismatches.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PHASE_ITEMS = 95;
   localparam int HOLD_CYCLES = 400;
   localparam int CYCLE_LIMIT = 8000000;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   rltc_pkg::req_word_type req_word;
   logic                   rsp_valid;
   logic                   rsp_stall;
   rltc_pkg::rsp_word_type rsp_word;

   int fail_count;
   int pending;
   int idle_pct;
   int stall_pct;
   int items_sent;
   int cycles = 0;
   bit hold_req;

   run_length_text_compressor dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   rltc_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_word   (req_word),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_word   (rsp_word),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // hard stop in case the block hangs or words go missing
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("run_length_text_compressor verification failed");
         $finish;
      end
   end

   // receiver: random stall, or one long hold-off when asked
   initial begin : receiver
      int n;
      bit held;
      rsp_stall = 1'b0;
      held      = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req && !held) begin
            // keep stall up so the output backs up into the input side
            rsp_stall <= 1'b1;
            for (n = 1; n < HOLD_CYCLES; n++) @(negedge clock);
            held = 1'b1;
         end else begin
            rsp_stall <= stall_pct != 0 && $urandom_range(99) < stall_pct;
         end
      end
   end

   // one word on the input channel; starts and ends at a falling edge,
   // valid stays up between back-to-back words
   task automatic send_byte(input logic [7:0] b, input logic eos);
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= '{in_byte: b, end_of_stream: eos};
      do @(posedge clock); while (req_stall);
      items_sent++;
      @(negedge clock);
   endtask

   // a stream of runs closed by an end mark, now and then plain noise
   task automatic send_stream();
      int         runs;
      int         r;
      int         len;
      int         k;
      int         pick;
      logic [7:0] b;
      if ($urandom_range(9) == 0) begin
         // noise: random bytes with end marks dropped anywhere
         len = $urandom_range(1, 20);
         for (k = 0; k < len; k++)
            send_byte(8'($urandom_range(255)), $urandom_range(5) == 0);
      end else begin
         runs = $urandom_range(1, 6);
         for (r = 0; r < runs; r++) begin
            // small alphabet half the time so neighbors often repeat
            if ($urandom_range(1) == 1) b = 8'h61 + 8'($urandom_range(3));
            else b = 8'($urandom_range(255));
            pick = $urandom_range(99);
            if (pick < 60) len = $urandom_range(1, 3);
            else if (pick < 95) len = $urandom_range(4, 15);
            else len = $urandom_range(16, 150);
            for (k = 0; k < len; k++)
               send_byte(b, r == runs - 1 && k == len - 1);
         end
      end
   endtask

   task automatic run_phase(input int idle, input int stall);
      int target;
      idle_pct  = idle;
      stall_pct = stall;
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) send_stream();
   endtask

   initial begin : stimulus
      int k;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_word   = '0;
      idle_pct   = 0;
      stall_pct  = 0;
      hold_req   = 1'b0;
      items_sent = 0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // lone zero byte that is also the whole stream
      send_byte(8'h00, 1'b1);
      // all-ones run closed by its end mark
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);
      // run of two closed by a new byte which then ends the stream
      send_byte(8'h61, 1'b0);
      send_byte(8'h61, 1'b0);
      send_byte(8'h62, 1'b1);
      // two-digit count with a zero digit
      for (k = 0; k < 10; k++) send_byte(8'h41, 1'b0);
      send_byte(8'h42, 1'b1);
      // alternating bits, no run longer than one
      send_byte(8'h55, 1'b0);
      send_byte(8'hAA, 1'b0);
      send_byte(8'h55, 1'b1);
      // end mark on a byte that extends the run
      send_byte(8'h7A, 1'b0);
      send_byte(8'h7A, 1'b1);

      // long receiver hold-off while the sender keeps pushing
      hold_req = 1'b1;
      run_phase(0, 0);
      run_phase(74, 0);
      run_phase(0, 74);
      run_phase(19, 19);
      send_byte(8'($urandom_range(255)), 1'b1);
      req_valid <= 1'b0;
      idle_pct  = 0;
      stall_pct = 0;

      while (pending != 0) @(negedge clock);
      // room for any stray word to show up
      repeat (40) @(negedge clock);
      if (fail_count == 0 && pending == 0)
         $display("run_length_text_compressor verification clean");
      else
         $display("run_length_text_compressor verification failed");
      $finish;
   end

endmodule
